// ----- hdl/mh_pkg.sv -----
// shared types and constants for the magnetometer heading unit
// holds payload structs, register indexes and the cordic arctangent table
package mh_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int SCALE_BITS    = 16;
    // corrected sample, fraction bits and two bits of cordic growth
    localparam int CORDIC_WIDTH  = SAMPLE_BITS + 1 + SCALE_BITS + 2;
    localparam int ACC_BITS      = 32;
    localparam int ANGLE_BITS    = 16;
    localparam int DEGREE_BITS   = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int ATAN_ENTRIES  = 25;

    localparam logic [CFG_IDX_BITS-1:0] REG_X_OFFSET       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_OFFSET       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEADING_OFFSET = 2'd2;

    localparam logic signed [SAMPLE_BITS-1:0] X_OFFSET_RESET       = 12'sd8;
    localparam logic signed [SAMPLE_BITS-1:0] Y_OFFSET_RESET       = -12'sd291;
    localparam logic signed [ANGLE_BITS-1:0]  HEADING_OFFSET_RESET = -16'sd70;

    localparam logic [ACC_BITS-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [DEGREE_BITS-1:0] DEGREES_PER_TURN = 9'd360;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ACC_BITS-1:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x_axis;
        logic signed [SAMPLE_BITS-1:0] y_axis;
    } t_mh_in;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]  heading_angle;
        logic [DEGREE_BITS-1:0] heading_degrees;
    } t_mh_out;

endpackage

// ----- hdl/mh_pre.sv -----
// front stage: hard-iron correction, left half plane turn and scaling
// depends on mh_pkg
module mh_pre (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  mh_pkg::t_mh_in                           i_word,
    output logic                                     o_ready,
    input  logic signed [mh_pkg::SAMPLE_BITS-1:0]    i_x_offset,
    input  logic signed [mh_pkg::SAMPLE_BITS-1:0]    i_y_offset,
    output logic                                     o_valid,
    output logic signed [mh_pkg::CORDIC_WIDTH-1:0]   o_x,
    output logic signed [mh_pkg::CORDIC_WIDTH-1:0]   o_y,
    output logic [mh_pkg::ACC_BITS-1:0]              o_acc,
    output logic                                     o_zero,
    input  logic                                     i_ready
);
    import mh_pkg::*;

    localparam int EXT_BITS = CORDIC_WIDTH - SAMPLE_BITS - 1 - SCALE_BITS;

    logic                           r_valid;
    logic signed [CORDIC_WIDTH-1:0] r_x, n_x;
    logic signed [CORDIC_WIDTH-1:0] r_y, n_y;
    logic [ACC_BITS-1:0]            r_acc, n_acc;
    logic                           r_zero, n_zero;
    logic signed [SAMPLE_BITS:0]    x_corr, y_corr, x_turn, y_turn;

    always_comb begin
        x_corr = $signed({i_word.x_axis[SAMPLE_BITS-1], i_word.x_axis})
               - $signed({i_x_offset[SAMPLE_BITS-1], i_x_offset});
        y_corr = $signed({i_word.y_axis[SAMPLE_BITS-1], i_word.y_axis})
               - $signed({i_y_offset[SAMPLE_BITS-1], i_y_offset});
        n_zero = (x_corr == '0) && (y_corr == '0);
        // corrected range stays within +-4095, so the negation cannot overflow
        if (x_corr[SAMPLE_BITS]) begin
            x_turn = -x_corr;
            y_turn = -y_corr;
            n_acc  = HALF_TURN;
        end else begin
            x_turn = x_corr;
            y_turn = y_corr;
            n_acc  = '0;
        end
        n_x = {{EXT_BITS{x_turn[SAMPLE_BITS]}}, x_turn, {SCALE_BITS{1'b0}}};
        n_y = {{EXT_BITS{y_turn[SAMPLE_BITS]}}, y_turn, {SCALE_BITS{1'b0}}};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_zero <= n_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_zero  = r_zero;

endmodule

// ----- hdl/mh_cell.sv -----
// one vectoring cordic rotation with its own pipeline register
// depends on mh_pkg for widths and the arctangent table
module mh_cell #(
    parameter int STAGE = 0
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic signed [mh_pkg::CORDIC_WIDTH-1:0]   i_x,
    input  logic signed [mh_pkg::CORDIC_WIDTH-1:0]   i_y,
    input  logic [mh_pkg::ACC_BITS-1:0]              i_acc,
    input  logic                                     i_zero,
    output logic                                     o_ready,
    output logic                                     o_valid,
    output logic signed [mh_pkg::CORDIC_WIDTH-1:0]   o_x,
    output logic signed [mh_pkg::CORDIC_WIDTH-1:0]   o_y,
    output logic [mh_pkg::ACC_BITS-1:0]              o_acc,
    output logic                                     o_zero,
    input  logic                                     i_ready
);
    import mh_pkg::*;

    logic                           r_valid;
    logic signed [CORDIC_WIDTH-1:0] r_x, n_x;
    logic signed [CORDIC_WIDTH-1:0] r_y, n_y;
    logic [ACC_BITS-1:0]            r_acc, n_acc;
    logic                           r_zero;
    logic signed [CORDIC_WIDTH-1:0] dx, dy;

    always_comb begin
        // arithmetic shift rounds toward minus infinity
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (!i_y[CORDIC_WIDTH-1]) begin
            n_x   = i_x + dx;
            n_y   = i_y - dy;
            n_acc = i_acc + ATAN_TURNS[STAGE];
        end else begin
            n_x   = i_x - dx;
            n_y   = i_y + dy;
            n_acc = i_acc - ATAN_TURNS[STAGE];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_zero <= i_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_zero  = r_zero;

endmodule

// ----- hdl/mh_post.sv -----
// back end: heading offset add, then degree conversion into the output register
// depends on mh_pkg
module mh_post (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [mh_pkg::ACC_BITS-1:0]            i_acc,
    input  logic                                   i_zero,
    output logic                                   o_ready,
    input  logic signed [mh_pkg::ANGLE_BITS-1:0]   i_heading_offset,
    output logic                                   o_valid,
    output mh_pkg::t_mh_out                        o_word,
    input  logic                                   i_ready
);
    import mh_pkg::*;

    localparam int PROD_BITS = ANGLE_BITS + DEGREE_BITS;

    logic                   r_a_valid;
    logic [ANGLE_BITS-1:0]  r_angle, n_angle;
    logic                   a_ready;
    logic                   r_o_valid;
    t_mh_out                r_word, n_word;
    logic [ACC_BITS-1:0]    acc_used;
    logic [PROD_BITS-1:0]   prod;

    always_comb begin
        // a zero vector has no direction: raw angle is zero
        acc_used = i_zero ? '0 : i_acc;
        n_angle  = acc_used[ACC_BITS-1 -: ANGLE_BITS] + i_heading_offset;
    end

    always_comb begin
        prod   = {{DEGREE_BITS{1'b0}}, r_angle} * {{ANGLE_BITS{1'b0}}, DEGREES_PER_TURN};
        n_word.heading_angle   = r_angle;
        n_word.heading_degrees = prod[PROD_BITS-1 -: DEGREE_BITS];
    end

    assign a_ready = !r_o_valid || i_ready;
    assign o_ready = !r_a_valid || a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (a_ready) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_angle <= n_angle;
        end
        if (a_ready && r_a_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_o_valid;
    assign o_word  = r_word;

endmodule

// ----- hdl/magnetometer_heading_unit.sv -----
// compass heading from a raw x/y magnetometer word, top level
// depends on mh_pkg, mh_pre, mh_cell and mh_post
//
// Takes one raw x/y sample per cycle, subtracts the hard-iron offsets, finds
// atan2(y, x) with a chain of CORDIC_STAGES vectoring cordic cells, adds the
// heading offset and returns the heading as a 16-bit binary angle plus whole
// degrees 0..359. Every stage is a registered cell, so a new word is taken
// every clock while the output side keeps up; the registered stages are the
// front stage, one cell per cordic iteration, the offset add and the degree
// multiply into the output register. A stalled output holds the full stages
// in the chain while empty stages keep accepting. Configuration writes
// (0 x offset, 1 y offset, 2 heading offset) take effect at once and are
// meant to happen with the unit idle.
module magnetometer_heading_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [mh_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [mh_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                  i_in_valid,
    input  mh_pkg::t_mh_in                        i_in_word,
    output logic                                  o_in_ready,
    output logic                                  o_out_valid,
    output mh_pkg::t_mh_out                       o_out_word,
    input  logic                                  i_out_ready
);
    import mh_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_x_offset;
    logic signed [SAMPLE_BITS-1:0] r_y_offset;
    logic signed [ANGLE_BITS-1:0]  r_heading_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset       <= X_OFFSET_RESET;
            r_y_offset       <= Y_OFFSET_RESET;
            r_heading_offset <= HEADING_OFFSET_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_X_OFFSET: begin
                    r_x_offset <= i_cfg_data[SAMPLE_BITS-1:0];
                end
                REG_Y_OFFSET: begin
                    r_y_offset <= i_cfg_data[SAMPLE_BITS-1:0];
                end
                REG_HEADING_OFFSET: begin
                    r_heading_offset <= i_cfg_data[ANGLE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // chain taps: index k feeds cell k, index CORDIC_STAGES feeds the back end
    logic                           s_valid [0:CORDIC_STAGES];
    logic                           s_ready [0:CORDIC_STAGES];
    logic signed [CORDIC_WIDTH-1:0] s_x     [0:CORDIC_STAGES];
    logic signed [CORDIC_WIDTH-1:0] s_y     [0:CORDIC_STAGES];
    logic [ACC_BITS-1:0]            s_acc   [0:CORDIC_STAGES];
    logic                           s_zero  [0:CORDIC_STAGES];

    mh_pre u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_word     (i_in_word),
        .o_ready    (o_in_ready),
        .i_x_offset (r_x_offset),
        .i_y_offset (r_y_offset),
        .o_valid    (s_valid[0]),
        .o_x        (s_x[0]),
        .o_y        (s_y[0]),
        .o_acc      (s_acc[0]),
        .o_zero     (s_zero[0]),
        .i_ready    (s_ready[0])
    );

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        mh_cell #(
            .STAGE (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .i_x     (s_x[k]),
            .i_y     (s_y[k]),
            .i_acc   (s_acc[k]),
            .i_zero  (s_zero[k]),
            .o_ready (s_ready[k]),
            .o_valid (s_valid[k+1]),
            .o_x     (s_x[k+1]),
            .o_y     (s_y[k+1]),
            .o_acc   (s_acc[k+1]),
            .o_zero  (s_zero[k+1]),
            .i_ready (s_ready[k+1])
        );
    end

    mh_post u_post (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_valid[CORDIC_STAGES]),
        .i_acc            (s_acc[CORDIC_STAGES]),
        .i_zero           (s_zero[CORDIC_STAGES]),
        .o_ready          (s_ready[CORDIC_STAGES]),
        .i_heading_offset (r_heading_offset),
        .o_valid          (o_out_valid),
        .o_word           (o_out_word),
        .i_ready          (i_out_ready)
    );

endmodule

// ----- bench/magnetometer_heading_unit_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for magnetometer_heading_unit: directed and random x/y words
// depends on mh_pkg and the rtl top; a scoreboard class predicts every heading word

class heading_scoreboard;
    int                             stages;
    logic signed [11:0]             x_off;
    logic signed [11:0]             y_off;
    logic signed [15:0]             hdg_off;
    logic [31:0]                    arctan_step [25];
    mh_pkg::t_mh_out                expected_headings [$];
    int                             errors;

    function new(int n_stages);
        stages  = n_stages;
        x_off   = mh_pkg::X_OFFSET_RESET;
        y_off   = mh_pkg::Y_OFFSET_RESET;
        hdg_off = mh_pkg::HEADING_OFFSET_RESET;
        errors  = 0;
        // atan(2^-i) in 2^-32 turn units
        arctan_step = '{
            32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
            32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
            32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
            32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
            32'd652,       32'd326,       32'd163,       32'd81,       32'd41
        };
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
        case (idx)
            mh_pkg::REG_X_OFFSET:       x_off = data[11:0];
            mh_pkg::REG_Y_OFFSET:       y_off = data[11:0];
            mh_pkg::REG_HEADING_OFFSET: hdg_off = data;
            default: ;
        endcase
    endfunction

    function mh_pkg::t_mh_out heading_of(mh_pkg::t_mh_in s);
        longint          cx;
        longint          cy;
        longint          dx;
        longint          dy;
        logic [31:0]     acc;
        logic [15:0]     ang;
        logic [31:0]     prod;
        mh_pkg::t_mh_out r;
        cx  = longint'(s.x_axis) - longint'(x_off);
        cy  = longint'(s.y_axis) - longint'(y_off);
        acc = 32'd0;
        if (cx != 0 || cy != 0) begin
            cx = cx * 65536;
            cy = cy * 65536;
            // left half plane: rotate by half a turn first
            if (cx < 0) begin
                cx  = -cx;
                cy  = -cy;
                acc = 32'h8000_0000;
            end
            for (int k = 0; k < stages && k < 25; k++) begin
                dx = cy >>> k;
                dy = cx >>> k;
                if (cy >= 0) begin
                    cx  = cx + dx;
                    cy  = cy - dy;
                    acc = acc + arctan_step[k];
                end else begin
                    cx  = cx - dx;
                    cy  = cy + dy;
                    acc = acc - arctan_step[k];
                end
            end
        end
        ang  = acc[31:16] + 16'(hdg_off);
        prod = 32'(ang) * 32'd360;
        r.heading_angle   = ang;
        r.heading_degrees = prod[24:16];
        return r;
    endfunction

    function void note_sample(mh_pkg::t_mh_in s);
        expected_headings.push_back(heading_of(s));
    endfunction

    function void check_heading(mh_pkg::t_mh_out got);
        mh_pkg::t_mh_out want;
        if (expected_headings.size() == 0) begin
            $error("heading word with no sample pending: angle %0d, degrees %0d",
                   got.heading_angle, got.heading_degrees);
            errors++;
            return;
        end
        want = expected_headings.pop_front();
        if (got.heading_angle !== want.heading_angle) begin
            $error("heading_angle mismatch: expected %0d, got %0d",
                   want.heading_angle, got.heading_angle);
            errors++;
        end
        if (got.heading_degrees !== want.heading_degrees) begin
            $error("heading_degrees mismatch: expected %0d, got %0d",
                   want.heading_degrees, got.heading_degrees);
            errors++;
        end
    endfunction
endclass

module magnetometer_heading_unit_tb;

    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 3;
    localparam logic [mh_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_wr_en = 1'b0;
    logic [mh_pkg::CFG_IDX_BITS-1:0]     i_cfg_index = '0;
    logic [mh_pkg::CFG_DATA_BITS-1:0]    i_cfg_data = '0;
    logic                                i_in_valid = 1'b0;
    mh_pkg::t_mh_in                      i_in_word = '0;
    logic                                o_in_ready;
    logic                                o_out_valid;
    mh_pkg::t_mh_out                     o_out_word;
    logic                                i_out_ready = 1'b0;

    heading_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_left = 0;

    magnetometer_heading_unit #(
        .CORDIC_STAGES(STAGES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_ready (i_out_ready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // output side: check accepted words, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_heading(o_out_word);
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("magnetometer_heading_unit regression: fail");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_offsets(input logic [15:0] xo, input logic [15:0] yo,
                               input logic [15:0] ho);
        write_reg(mh_pkg::REG_X_OFFSET, xo);
        write_reg(mh_pkg::REG_Y_OFFSET, yo);
        write_reg(mh_pkg::REG_HEADING_OFFSET, ho);
    endtask

    task automatic send_sample(input int xv, input int yv);
        mh_pkg::t_mh_in w;
        w.x_axis = 12'(xv);
        w.y_axis = 12'(yv);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(w);
    endtask

    task automatic wait_empty();
        i_in_valid <= 1'b0;
        while (sb.expected_headings.size() != 0) @(posedge i_clk);
    endtask

    // mostly full-range words, some close to the offset point for tiny vectors
    task automatic send_random(input int count);
        int xv;
        int yv;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                xv = int'(sb.x_off) + $urandom_range(0, 8) - 4;
                yv = int'(sb.y_off) + $urandom_range(0, 8) - 4;
            end else begin
                xv = $urandom_range(0, 4095);
                yv = $urandom_range(0, 4095);
            end
            send_sample(xv, yv);
        end
    endtask

    task automatic random_offsets();
        set_offsets(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
    endtask

    initial begin
        sb = new(STAGES);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset offsets: zero vector, the four axis directions, corners
        send_sample(8, -291);
        send_sample(9, -291);
        send_sample(7, -291);
        send_sample(8, -290);
        send_sample(8, -292);
        send_sample(2047, 2047);
        send_sample(-2048, -2048);
        send_sample(-2048, 2047);
        send_sample(2047, -2048);
        send_sample(1008, -291);
        send_sample(-992, -290);
        send_sample(108, -391);
        wait_empty();

        // extreme offsets give the widest corrected vectors
        set_offsets(16'(-2048), 16'(2047), 16'(32767));
        send_sample(-2048, 2047);
        send_sample(2047, -2048);
        send_sample(2047, 2047);
        send_sample(-2048, -2048);
        wait_empty();

        // write to the unused index is dropped, upper data bits of x offset too
        write_reg(REG_UNUSED, 16'h1234);
        set_offsets(16'hF005, 16'h0000, 16'h8000);
        send_sample(5, 0);
        send_sample(-2048, 0);
        send_sample(0, 2047);
        send_sample(100, -2048);
        wait_empty();

        set_offsets(16'(2047), 16'(-2048), 16'(-32768));
        tx_idle_pct  = 8;
        rx_stall_pct = 83;
        send_random(520);
        wait_empty();

        random_offsets();
        tx_idle_pct  = 83;
        rx_stall_pct = 8;
        send_random(520);
        wait_empty();

        random_offsets();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_random(520);
        wait_empty();

        // long output stall with the input side pushing until the pipe backs up
        random_offsets();
        hold_left = 4 * LATENCY;
        send_random(120);
        wait_empty();

        repeat (LATENCY + 8) @(posedge i_clk);
        if (sb.expected_headings.size() != 0) begin
            $error("%0d heading words never arrived", sb.expected_headings.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("magnetometer_heading_unit regression: pass");
        end else begin
            $display("magnetometer_heading_unit regression: fail");
        end
        $finish;
    end

endmodule
